// File: hdl/ctmc_pkg.sv
// Shared types and constants for the class transition matrix counter.
// Holds the function codes, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctmc_pkg;

  localparam int MAX_CLASSES_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;

  localparam int CODE_W     = 16;
  localparam int FUNC_W     = 2;
  localparam int RC_W       = 4;
  localparam int CNT_OUT_W  = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int OFF_W      = CODE_W + 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ACC   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_CODE  = 1'b0,
    CFG_HIGH_CODE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_CLEAR,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;   // latch the accepted transaction
    logic check;     // register range check and cell index
    logic rd_en;     // read the addressed cell
    logic clr_wr;    // write one zero of the clearing sweep
    logic upd;       // finish: write back and load the result register
  } cmd_t;

  typedef struct packed {
    logic is_clear;  // captured transaction is a clear
    logic clr_last;  // sweep is at its last cell
    logic out_free;  // result register can take a new result this cycle
  } status_t;

endpackage

`default_nettype wire

// File: hdl/ctmc_ctrl.sv
// Controller state machine for the class transition matrix counter.
// Sequences capture, check, read, clear sweep and update. Uses ctmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctmc_ctrl
  import ctmc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t sts,
  output cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = sts.is_clear ? ST_CLEAR : ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_INIT: begin
        cmd.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      ST_UPDATE: begin
        cmd.upd = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/ctmc_dp.sv
// Datapath for the class transition matrix counter: configuration registers,
// range check, count memory, clearing counter and result register. Uses ctmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctmc_dp
  import ctmc_pkg::*;
#(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cmd_t                         cmd,
  output status_t                           sts,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_idx,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data,
  input  wire logic [FUNC_W-1:0]            in_func,
  input  wire logic signed [CODE_W-1:0]     in_first_code,
  input  wire logic signed [CODE_W-1:0]     in_second_code,
  input  wire logic [RC_W-1:0]              in_read_row,
  input  wire logic [RC_W-1:0]              in_read_col,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic [CNT_OUT_W-1:0]              out_cell_count,
  output logic                              out_pair_counted,
  output logic                              out_count_saturated
);

  localparam int CELLS = MAX_CLASSES * MAX_CLASSES;
  localparam int IDX_W = $clog2(CELLS);
  localparam int ROW_W = $clog2(MAX_CLASSES);
  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CELLS - 1);
  localparam logic [IDX_W-1:0] ROW_STEP  = IDX_W'(MAX_CLASSES);
  localparam logic [OFF_W-1:0] OFF_LIM   = OFF_W'(MAX_CLASSES);

  // Configuration.
  logic signed [CODE_W-1:0] low_code_r;
  logic signed [CODE_W-1:0] high_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_code_r  <= CODE_W'(1);
      high_code_r <= CODE_W'(16);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        CFG_LOW_CODE:  low_code_r  <= cfg_data;
        CFG_HIGH_CODE: high_code_r <= cfg_data;
        default: begin
          low_code_r <= low_code_r;
        end
      endcase
    end
  end

  // Captured transaction.
  func_t                    func_r;
  logic signed [CODE_W-1:0] first_r;
  logic signed [CODE_W-1:0] second_r;
  logic [RC_W-1:0]          row_r;
  logic [RC_W-1:0]          col_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r   <= func_t'(in_func);
      first_r  <= in_first_code;
      second_r <= in_second_code;
      row_r    <= in_read_row;
      col_r    <= in_read_col;
    end
  end

  // Range check and cell index.
  logic             acc_ok;
  logic             rd_ok;
  logic [OFF_W-1:0] off_a;
  logic [OFF_W-1:0] off_b;
  logic [IDX_W-1:0] acc_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             hit_nxt;
  logic [IDX_W-1:0] idx_nxt;
  logic             hit_r;
  logic [IDX_W-1:0] idx_r;

  always_comb begin
    off_a   = {first_r[CODE_W-1], first_r} - {low_code_r[CODE_W-1], low_code_r};
    off_b   = {second_r[CODE_W-1], second_r} - {low_code_r[CODE_W-1], low_code_r};
    acc_ok  = (first_r >= low_code_r) && (first_r <= high_code_r) &&
              (second_r >= low_code_r) && (second_r <= high_code_r) &&
              (off_a < OFF_LIM) && (off_b < OFF_LIM);
    acc_idx = IDX_W'(off_a[ROW_W-1:0]) * ROW_STEP + IDX_W'(off_b[ROW_W-1:0]);
    rd_ok   = (OFF_W'(row_r) < OFF_LIM) && (OFF_W'(col_r) < OFF_LIM);
    rd_idx  = IDX_W'(row_r) * ROW_STEP + IDX_W'(col_r);
    case (func_r)
      FUNC_ACC: begin
        hit_nxt = acc_ok;
        idx_nxt = acc_idx;
      end
      FUNC_READ: begin
        hit_nxt = rd_ok;
        idx_nxt = rd_idx;
      end
      default: begin
        hit_nxt = 1'b0;
        idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      hit_r <= hit_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Clearing sweep counter.
  logic [IDX_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= (clr_cnt_r == LAST_CELL) ? '0 : clr_cnt_r + IDX_W'(1);
    end
  end

  // Count memory, one write port and one registered read port.
  logic [COUNT_BITS-1:0] count_mem [CELLS];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic [COUNT_BITS-1:0] new_count;
  logic                  old_sat;
  logic                  new_sat;
  logic                  acc_wr;

  always_comb begin
    old_sat   = (rd_data_r == '1);
    new_count = old_sat ? rd_data_r : rd_data_r + COUNT_BITS'(1);
    new_sat   = (new_count == '1);
    acc_wr    = cmd.upd && hit_r && (func_r == FUNC_ACC);
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      count_mem[clr_cnt_r] <= '0;
    end else if (acc_wr) begin
      count_mem[idx_r] <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= count_mem[idx_r];
    end
  end

  // Result register.
  logic                 out_valid_r;
  logic [CNT_OUT_W-1:0] cnt_out_r;
  logic                 counted_r;
  logic                 sat_r;
  logic [63:0]          new_wide;
  logic [63:0]          old_wide;

  assign new_wide = 64'(new_count);
  assign old_wide = 64'(rd_data_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.upd) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      cnt_out_r <= '0;
      counted_r <= 1'b0;
      sat_r     <= 1'b0;
      if (hit_r && func_r == FUNC_ACC) begin
        cnt_out_r <= new_wide[CNT_OUT_W-1:0];
        counted_r <= 1'b1;
        sat_r     <= new_sat;
      end else if (hit_r && func_r == FUNC_READ) begin
        cnt_out_r <= old_wide[CNT_OUT_W-1:0];
        sat_r     <= old_sat;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cell_count      = cnt_out_r;
  assign out_pair_counted    = counted_r;
  assign out_count_saturated = sat_r;

  assign sts.is_clear = (func_r == FUNC_CLEAR);
  assign sts.clr_last = (clr_cnt_r == LAST_CELL);
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

// File: hdl/class_transition_matrix_counter.sv
// Transactions are taken one at a time: an accumulate, read or unused code passes
// through the check, read and update states, a clear through check, a sweep and update.
// Intake stays closed from acceptance until the result is loaded, as each
// transaction is a read-modify-write on the count memory. A waiting result does not block intake.
// Reset: synchronous, active low. Afterwards the memory is zeroed by a sweep over all
// MAX_CLASSES*MAX_CLASSES cells during which in_stall stays high. Depends on ctmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module class_transition_matrix_counter
  import ctmc_pkg::*;
#(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Configuration write port: index 0 is low_code, index 1 is high_code.
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  // Input transaction channel.
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [FUNC_W-1:0]        in_func,
  input  wire logic signed [CODE_W-1:0] in_first_code,
  input  wire logic signed [CODE_W-1:0] in_second_code,
  input  wire logic [RC_W-1:0]          in_read_row,
  input  wire logic [RC_W-1:0]          in_read_col,
  // Result transaction channel.
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [CNT_OUT_W-1:0]          out_cell_count,
  output logic                          out_pair_counted,
  output logic                          out_count_saturated
);

  // The controller only sequences; every stored value lives in the datapath.
  // An accepted transaction is latched, checked against the class range and
  // turned into a cell index, the cell is read from memory, and in the update
  // cycle an accumulate writes the incremented count back as the result register is
  // loaded. A clear replaces the read with a sweep that zeroes one cell per
  // cycle. The result register decouples the output side: intake reopens as
  // soon as the result is loaded, even if it has not been taken yet.
  cmd_t    cmd;
  status_t sts;

  ctmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ctmc_dp #(
    .MAX_CLASSES (MAX_CLASSES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_data            (cfg_data),
    .in_func             (in_func),
    .in_first_code       (in_first_code),
    .in_second_code      (in_second_code),
    .in_read_row         (in_read_row),
    .in_read_col         (in_read_col),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_cell_count      (out_cell_count),
    .out_pair_counted    (out_pair_counted),
    .out_count_saturated (out_count_saturated)
  );

endmodule

`default_nettype wire

// File: hdl/ctmc_checker.sv
// Port-level checker for the class transition matrix counter, bound to the top level.
// Uses ctmc_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none

module ctmc_checker
  import ctmc_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic                     out_pair_counted,
  input wire logic                     out_count_saturated,
  input wire logic [CNT_OUT_W-1:0]     out_cell_count
);

  // Intake is closed right after reset while the memory is being zeroed.
  a_stall_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("intake open right after reset");

  // Only one transaction is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction accepted back to back");

  // A new result never appears in the cycle after an acceptance.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A stalled result is held.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_cell_count) &&
      $stable(out_pair_counted) && $stable(out_count_saturated)))
    else $error("stalled result changed");

endmodule

bind class_transition_matrix_counter ctmc_checker u_ctmc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_pair_counted    (out_pair_counted),
  .out_count_saturated (out_count_saturated),
  .out_cell_count      (out_cell_count)
);

`default_nettype wire
